FILE: rtl/ffbr_pkg.sv
package ffbr_pkg;

	localparam int DEF_MAX_BLOCKS = 1024;

	localparam int OP_W   = 1;
	localparam int IDX_W  = 10;
	localparam int KIND_W = 2;
	localparam int LEN_W  = 11;
	localparam int VOL_W  = 11;
	localparam int STAT_W = 2;

	localparam logic [VOL_W-1:0] VOL_RESET = 11'd1024;

	typedef logic [STAT_W-1:0] status_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OP_W-1:0] OP_FIND  = 1'b1;

	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_NOSPACE = 2'd1;
	localparam status_t STAT_RANGE   = 2'd2;

	localparam kind_t KIND_UNUSED = 2'd0;

endpackage

FILE: rtl/first_fit_block_run_finder_top.sv
// First-fit block run finder.
// Holds a 2-bit type per block and answers two kinds of request on the
// in_valid/in_ready channel: opcode 0 writes block_kind at block_index,
// opcode 1 looks for the lowest start of run_length consecutive unused
// blocks inside the volume. Each request gives one result on the
// out_valid/out_ready channel (start_block, status).
// cfg_we/cfg_wdata set the volume size; write it only while idle.
// A write request passes through the result state into the output
// register. A find request walks the table one entry per cycle through
// its single read port from block 0 and stops at the first run that
// fits or at the last block of the volume; zero-length or oversize
// requests skip the walk. One request is in flight at a time.
// After reset the table is cleared by a pass over all MAX_BLOCKS entries,
// during which in_ready is low; configuration writes are taken throughout.
// A finished result sits in the output register while the receiver
// stalls; the next request is still accepted and holds its result until
// the output register frees up.
module first_fit_block_run_finder_top #(
	parameter int MAX_BLOCKS = ffbr_pkg::DEF_MAX_BLOCKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ffbr_pkg::VOL_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ffbr_pkg::OP_W-1:0]     opcode,
	input  logic [ffbr_pkg::IDX_W-1:0]    block_index,
	input  ffbr_pkg::kind_t               block_kind,
	input  logic [ffbr_pkg::LEN_W-1:0]    run_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ffbr_pkg::IDX_W-1:0]    start_block,
	output ffbr_pkg::status_t             status
);
	import ffbr_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	kind_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	kind_t         mem_rdata;

	ffbr_table #(
		.DEPTH (MAX_BLOCKS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ffbr_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.AW         (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.block_index (block_index),
		.block_kind  (block_kind),
		.run_length  (run_length),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.start_block (start_block),
		.status      (status),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

endmodule

FILE: rtl/ffbr_table.sv
module ffbr_table #(
	parameter int DEPTH = ffbr_pkg::DEF_MAX_BLOCKS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  ffbr_pkg::kind_t           wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output ffbr_pkg::kind_t           rdata
);
	import ffbr_pkg::*;

	kind_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/ffbr_ctrl.sv
module ffbr_ctrl #(
	parameter int MAX_BLOCKS = ffbr_pkg::DEF_MAX_BLOCKS,
	parameter int AW         = $clog2(MAX_BLOCKS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ffbr_pkg::VOL_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ffbr_pkg::OP_W-1:0]     opcode,
	input  logic [ffbr_pkg::IDX_W-1:0]    block_index,
	input  ffbr_pkg::kind_t               block_kind,
	input  logic [ffbr_pkg::LEN_W-1:0]    run_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ffbr_pkg::IDX_W-1:0]    start_block,
	output ffbr_pkg::status_t             status,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output ffbr_pkg::kind_t               mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  ffbr_pkg::kind_t               mem_rdata
);
	import ffbr_pkg::*;

	localparam int EW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

	localparam logic [1:0] S_CLEAR  = 2'd0;
	localparam logic [1:0] S_IDLE   = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_RESULT = 2'd3;

	logic [1:0]       state_q;
	logic [VOL_W-1:0] volume_q;
	logic [AW-1:0]    addr_q;
	logic             issue_q;
	logic             chk_s1;
	logic [AW-1:0]    idx_s1;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] run_q;
	logic [IDX_W-1:0] res_start_q;
	status_t          res_status_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] start_block_q;
	status_t          status_q;

	logic [EW-1:0]    vol_cfg;
	logic [EW-1:0]    vol_eff;
	logic [EW-1:0]    idx_ext;
	logic [EW-1:0]    len_ext;
	logic [AW-1:0]    last_idx;
	logic [LEN_W-1:0] run_nx;
	logic [EW-1:0]    start_calc;
	logic             accept;
	logic             in_range;
	logic             load_out;
	logic             hit;

	assign vol_cfg    = EW'(volume_q);
	assign vol_eff    = (vol_cfg > EW'(MAX_BLOCKS)) ? EW'(MAX_BLOCKS) : vol_cfg;
	assign idx_ext    = EW'(block_index);
	assign len_ext    = EW'(run_length);
	assign last_idx   = AW'(vol_eff - EW'(1));
	assign in_range   = idx_ext < vol_eff;
	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign run_nx     = run_q + LEN_W'(1);
	assign hit        = chk_s1 && (mem_rdata == KIND_UNUSED) && (run_nx == len_q);
	assign start_calc = EW'(idx_s1) + EW'(1) - EW'(len_q);
	assign load_out   = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = KIND_UNUSED;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && opcode == OP_WRITE && in_range) begin
			mem_we    = 1'b1;
			mem_waddr = idx_ext[AW-1:0];
			mem_wdata = block_kind;
		end
	end

	assign mem_re    = (state_q == S_SCAN) && issue_q;
	assign mem_raddr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= VOL_RESET;
		end else if (cfg_we) begin
			volume_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q  <= '0;
			issue_q <= 1'b0;
			chk_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(MAX_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_WRITE) begin
							state_q <= S_RESULT;
						end else if (run_length == '0 || len_ext > vol_eff) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
							addr_q  <= '0;
							issue_q <= 1'b1;
							chk_s1  <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (hit || (chk_s1 && idx_s1 == last_idx)) begin
						state_q <= S_RESULT;
						issue_q <= 1'b0;
						chk_s1  <= 1'b0;
					end else begin
						chk_s1 <= issue_q;
						if (issue_q) begin
							if (addr_q == last_idx) begin
								issue_q <= 1'b0;
							end else begin
								addr_q <= addr_q + AW'(1);
							end
						end
					end
				end
				S_RESULT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && issue_q) begin
			idx_s1 <= addr_q;
		end
		if (accept) begin
			len_q       <= run_length;
			run_q       <= '0;
			res_start_q <= '0;
			if (opcode == OP_WRITE) begin
				res_status_q <= in_range ? STAT_OK : STAT_RANGE;
			end else begin
				res_status_q <= STAT_NOSPACE;
			end
		end else if (state_q == S_SCAN && chk_s1) begin
			if (mem_rdata == KIND_UNUSED) begin
				run_q <= run_nx;
			end else begin
				run_q <= '0;
			end
			if (hit) begin
				res_start_q  <= start_calc[IDX_W-1:0];
				res_status_q <= STAT_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			start_block_q <= res_start_q;
			status_q      <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign start_block = start_block_q;
	assign status      = status_q;

	a_chk_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> state_q == S_SCAN)
		else $error("table compare outside scan");

	a_run_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> run_q < len_q)
		else $error("run count reached requested length without a hit");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> !mem_we)
		else $error("table written during scan");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second request taken while one is in flight");

endmodule
